// ===== rtl/core/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Control frame parser package
// Constants and types shared by the control frame parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

	localparam logic [7:0] HDR_FIRST     = 8'hAA;
	localparam logic [7:0] HDR_SECOND    = 8'h55;
	localparam int         LEN_OVERHEAD  = 4;
	localparam int         FIRST_CAPTURE = 3;
	localparam int         NUM_EARLY     = 11;
	localparam int         LATE_INDEX    = 18;
	localparam int         NUM_CAPTURED  = 12;

	typedef struct packed {
		logic [7:0] depth_hold;
		logic [7:0] heading_lock;
		logic [7:0] master_enable;
		logic [7:0] surge;
		logic [7:0] sway;
		logic [7:0] heave;
		logic [7:0] yaw_rate;
		logic [7:0] thrust_gain;
		logic [7:0] lamp;
		logic [7:0] camera_zoom;
		logic [7:0] gimbal;
		logic [7:0] manipulator;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/cfp_if.sv =====
// ----------------------------------------------------------------------------
// Control frame parser channels
// Valid/ready channels for received frame bytes and decoded command requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface cfp_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] depth_hold;
	logic [7:0] heading_lock;
	logic [7:0] master_enable;
	logic [7:0] surge;
	logic [7:0] sway;
	logic [7:0] heave;
	logic [7:0] yaw_rate;
	logic [7:0] thrust_gain;
	logic [7:0] lamp;
	logic [7:0] camera_zoom;
	logic [7:0] gimbal;
	logic [7:0] manipulator;

	modport source (
		output valid, output depth_hold, output heading_lock, output master_enable,
		output surge, output sway, output heave, output yaw_rate, output thrust_gain,
		output lamp, output camera_zoom, output gimbal, output manipulator,
		input ready
	);
	modport sink (
		input valid, input depth_hold, input heading_lock, input master_enable,
		input surge, input sway, input heave, input yaw_rate, input thrust_gain,
		input lamp, input camera_zoom, input gimbal, input manipulator,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/cfp_engine.sv =====
// ----------------------------------------------------------------------------
// Control frame parser engine
// Tracks the byte position, header and length checks, the running checksum
// and the captured command bytes; flags a passing frame on its final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_engine
	import cfp_pkg::*;
#(
	parameter int FRAME_LEN = 22
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_start,
	output logic            emit,
	output cmd_t            cmd
);

	localparam int             PosW     = $clog2(FRAME_LEN + 1);
	localparam logic [PosW-1:0] PosIdle = PosW'(FRAME_LEN);
	localparam logic [PosW-1:0] PosLast = PosW'(FRAME_LEN - 1);
	localparam logic [7:0]      LenByte = 8'(FRAME_LEN - LEN_OVERHEAD);

	logic [PosW-1:0] pos_q;
	logic [7:0]      sum_q;
	logic            good_q;
	logic [7:0]      cap_q [NUM_CAPTURED];

	logic [PosW-1:0] idx;
	logic            act;

	assign idx  = frame_start ? '0 : pos_q;
	assign act  = step && (frame_start || (pos_q < PosIdle));
	assign emit = act && (idx == PosLast) && good_q && (sum_q == rx_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= PosIdle;
			sum_q  <= '0;
			good_q <= 1'b0;
		end else if (act) begin
			pos_q <= idx + PosW'(1);
			if (idx == '0) begin
				sum_q  <= rx_byte;
				good_q <= (rx_byte == HDR_FIRST);
			end else begin
				if (idx < PosLast) begin
					sum_q <= sum_q + rx_byte;
				end
				if (idx == PosW'(1)) begin
					good_q <= good_q && (rx_byte == HDR_SECOND);
				end else if (idx == PosW'(2)) begin
					good_q <= good_q && (rx_byte == LenByte);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act) begin
			for (int k = 0; k < NUM_EARLY; k++) begin
				if (idx == PosW'(FIRST_CAPTURE + k)) begin
					cap_q[k] <= rx_byte;
				end
			end
			if (idx == PosW'(LATE_INDEX)) begin
				cap_q[NUM_CAPTURED-1] <= rx_byte;
			end
		end
	end

	always_comb begin
		cmd.depth_hold    = cap_q[0];
		cmd.heading_lock  = cap_q[1];
		cmd.master_enable = cap_q[NUM_CAPTURED-1];
		cmd.surge         = cap_q[2];
		cmd.sway          = cap_q[3];
		cmd.heave         = cap_q[4];
		cmd.yaw_rate      = cap_q[5];
		cmd.thrust_gain   = cap_q[6];
		cmd.lamp          = cap_q[7];
		cmd.camera_zoom   = cap_q[8];
		cmd.gimbal        = cap_q[9];
		cmd.manipulator   = cap_q[10];
	end

endmodule

`default_nettype wire

// ===== rtl/core/control_frame_parser.sv =====
// Bytes pass the input register; the command request valid is also registered.
// Throughput: one byte per cycle while the command request is taken promptly.
// A pending command request stalls the byte input only once the input register
// is also full. Reset clears the position to idle, the checksum, the checks and
// all valid flags; captured bytes are not reset.
// ----------------------------------------------------------------------------
// Control frame parser
// Byte-serial parser for fixed-length control frames with additive checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module control_frame_parser
	import cfp_pkg::*;
#(
	parameter int FRAME_LEN = 22
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cfp_rx_if.sink    rx,
	cfp_cmd_if.source cmd
);

	logic [7:0] byte_s1;
	logic       start_s1;
	logic       valid_s1;
	logic       out_valid_q;
	logic       adv;
	logic       emit;
	cmd_t       cmd_w;

	assign adv      = !out_valid_q || cmd.ready;
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (adv) begin
				out_valid_q <= valid_s1 && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1  <= rx.rx_byte;
			start_s1 <= rx.frame_start;
		end
	end

	cfp_engine #(
		.FRAME_LEN(FRAME_LEN)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (valid_s1 && adv),
		.rx_byte    (byte_s1),
		.frame_start(start_s1),
		.emit       (emit),
		.cmd        (cmd_w)
	);

	assign cmd.valid         = out_valid_q;
	assign cmd.depth_hold    = cmd_w.depth_hold;
	assign cmd.heading_lock  = cmd_w.heading_lock;
	assign cmd.master_enable = cmd_w.master_enable;
	assign cmd.surge         = cmd_w.surge;
	assign cmd.sway          = cmd_w.sway;
	assign cmd.heave         = cmd_w.heave;
	assign cmd.yaw_rate      = cmd_w.yaw_rate;
	assign cmd.thrust_gain   = cmd_w.thrust_gain;
	assign cmd.lamp          = cmd_w.lamp;
	assign cmd.camera_zoom   = cmd_w.camera_zoom;
	assign cmd.gimbal        = cmd_w.gimbal;
	assign cmd.manipulator   = cmd_w.manipulator;

endmodule

`default_nettype wire

// ===== rtl/core/cfp_checker.sv =====
// ----------------------------------------------------------------------------
// Control frame parser checker
// Port-level checks on the parser's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rx_ready,
	input wire logic cmd_valid,
	input wire logic cmd_ready
);

	a_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid)
		else $error("Command request dropped before it was taken.");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !cmd_valid)
		else $error("Command request shown during reset.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_valid |-> rx_ready)
		else $error("Byte input stalled with no command request pending.");

	a_ready_on_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |-> rx_ready)
		else $error("Byte input stalled while the command request is taken.");

endmodule

bind control_frame_parser cfp_checker u_cfp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rx_ready (rx.ready),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready)
);

`default_nettype wire
